// ----- src/ftj_pkg.sv -----
// ---------------------------------------------------------------------------
// ftj_pkg
// Shared types, codes and helpers of the fault-transition journal.
// ---------------------------------------------------------------------------
package ftj_pkg;

	localparam int TIME_W    = 42;
	localparam int UPTIME_W  = 64;
	localparam int SESSION_W = 32;
	localparam int CODE_W    = 3;
	localparam int CFG_IDX_W = 1;

	localparam logic [TIME_W-1:0] MIN_TIME_RST = 42'd1700000000000;
	localparam logic [TIME_W-1:0] MAX_TIME_RST = 42'd4102444800000;

	// Operation codes.
	localparam logic OP_OBSERVE = 1'b0;
	localparam logic OP_ACK     = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TIME = 1'b1;

	typedef struct packed {
		logic                 opcode;
		logic [CODE_W-1:0]    fault_code;
		logic                 is_active;
		logic [SESSION_W-1:0] session_id;
		logic [UPTIME_W-1:0]  uptime_ms;
		logic [TIME_W-1:0]    wall_ms;
	} item_t;

	typedef struct packed {
		logic                 accepted;
		logic                 head_present;
		logic [CODE_W-1:0]    head_fault;
		logic                 head_active;
	} res_t;

	// Everything needed to fold one acknowledge into the per-kind ack time.
	typedef struct packed {
		logic                 valid;
		logic [CODE_W-1:0]    fault;
		logic [TIME_W-1:0]    head_wall;
		logic [SESSION_W-1:0] head_session;
		logic [UPTIME_W-1:0]  head_uptime;
		logic [TIME_W-1:0]    report;
		logic [SESSION_W-1:0] session;
		logic [UPTIME_W-1:0]  uptime;
		logic [TIME_W-1:0]    min_time;
		logic [TIME_W-1:0]    max_time;
	} ack_req_t;

	function automatic logic in_window(input logic [TIME_W-1:0] t,
		input logic [TIME_W-1:0] lo, input logic [TIME_W-1:0] hi);
		return (t >= lo) && (t < hi);
	endfunction

endpackage

// ----- src/ftj_ifs.sv -----
// ---------------------------------------------------------------------------
// ftj interfaces
// Request, result and configuration channels of the fault-transition journal.
// ---------------------------------------------------------------------------
interface ftj_in_if;
	logic                            valid;
	logic                            ready;
	logic                            opcode;
	logic [ftj_pkg::CODE_W-1:0]      fault_code;
	logic                            is_active;
	logic [ftj_pkg::SESSION_W-1:0]   session_id;
	logic [ftj_pkg::UPTIME_W-1:0]    uptime_ms;
	logic [ftj_pkg::TIME_W-1:0]      wall_ms;

	modport source (output valid, opcode, fault_code, is_active, session_id, uptime_ms,
		wall_ms, input ready);
	modport sink (input valid, opcode, fault_code, is_active, session_id, uptime_ms,
		wall_ms, output ready);
endinterface

interface ftj_out_if #(parameter int CNT_W = 5);
	logic                       valid;
	logic                       ready;
	logic                       accepted;
	logic [CNT_W-1:0]           queued_count;
	logic                       head_present;
	logic [ftj_pkg::CODE_W-1:0] head_fault;
	logic                       head_active;

	modport source (output valid, accepted, queued_count, head_present, head_fault,
		head_active, input ready);
	modport sink (input valid, accepted, queued_count, head_present, head_fault,
		head_active, output ready);
endinterface

interface ftj_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [ftj_pkg::CFG_IDX_W-1:0]     index;
	logic [ftj_pkg::TIME_W-1:0]        data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/ftj_journal.sv -----
// ---------------------------------------------------------------------------
// ftj_journal
// Ring-buffer journal of fault transitions and the known state of each kind.
// ---------------------------------------------------------------------------
module ftj_journal #(
	parameter int DEPTH = 16,
	parameter int FAULT_KINDS = 7,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  ftj_pkg::item_t                  item,
	input  logic [ftj_pkg::TIME_W-1:0]      min_time,
	input  logic [ftj_pkg::TIME_W-1:0]      max_time,
	output ftj_pkg::res_t                   res,
	output logic [CNT_W-1:0]                queued_count,
	output ftj_pkg::ack_req_t               ack_req
);

	logic [PTR_W-1:0] head_q, tail_q, head_inc, tail_inc;
	logic [CNT_W-1:0] fill_q, fill_next;
	logic [FAULT_KINDS-1:0] known_q, last_q, code_hot;

	// Fault code and flag are kept twice so the entry at the head and the one
	// behind it can both be read in the same cycle.
	logic [ftj_pkg::CODE_W-1:0]    cur_fault_mem [DEPTH];
	logic                          cur_active_mem [DEPTH];
	logic [ftj_pkg::CODE_W-1:0]    nxt_fault_mem [DEPTH];
	logic                          nxt_active_mem [DEPTH];
	logic [ftj_pkg::SESSION_W-1:0] session_mem [DEPTH];
	logic [ftj_pkg::UPTIME_W-1:0]  uptime_mem [DEPTH];
	logic [ftj_pkg::TIME_W-1:0]    wall_mem [DEPTH];

	logic wall_ok, obs_valid, is_repeat, full, empty, push, pop, ok;

	assign head_inc = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign full  = (fill_q == CNT_W'(DEPTH));
	assign empty = (fill_q == '0);

	always_comb begin
		for (int i = 0; i < FAULT_KINDS; i++) begin
			code_hot[i] = (32'(item.fault_code) == i);
		end
	end

	assign wall_ok = (item.wall_ms == '0) || ftj_pkg::in_window(item.wall_ms, min_time,
		max_time);
	assign obs_valid = (32'(item.fault_code) < FAULT_KINDS) && (item.session_id != '0)
		&& wall_ok;
	assign is_repeat = |(known_q & code_hot & ~(last_q ^ {FAULT_KINDS{item.is_active}}));

	always_comb begin
		push = 1'b0;
		pop  = 1'b0;
		ok   = 1'b0;
		if (item.opcode == ftj_pkg::OP_OBSERVE) begin
			push = fire && obs_valid && !is_repeat && !full;
			ok   = obs_valid && (is_repeat || !full);
		end else begin
			pop = fire && !empty && wall_ok;
			ok  = !empty && wall_ok;
		end
	end

	always_comb begin
		fill_next = fill_q;
		if (push) begin
			fill_next = fill_q + 1'b1;
		end else if (pop) begin
			fill_next = fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			fill_q  <= '0;
			known_q <= '0;
			last_q  <= '0;
		end else begin
			fill_q <= fill_next;
			if (push) begin
				tail_q  <= tail_inc;
				known_q <= known_q | code_hot;
				last_q  <= (last_q & ~code_hot) | (code_hot & {FAULT_KINDS{item.is_active}});
			end
			if (pop) begin
				head_q <= head_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cur_fault_mem[tail_q]  <= item.fault_code;
			cur_active_mem[tail_q] <= item.is_active;
			nxt_fault_mem[tail_q]  <= item.fault_code;
			nxt_active_mem[tail_q] <= item.is_active;
			session_mem[tail_q]    <= item.session_id;
			uptime_mem[tail_q]     <= item.uptime_ms;
			wall_mem[tail_q]       <= item.wall_ms;
		end
	end

	always_comb begin
		res.accepted     = ok;
		res.head_present = (fill_next != '0);
		res.head_fault   = '0;
		res.head_active  = 1'b0;
		if (fill_next != '0) begin
			if (push && empty) begin
				res.head_fault  = item.fault_code;
				res.head_active = item.is_active;
			end else if (pop) begin
				res.head_fault  = nxt_fault_mem[head_inc];
				res.head_active = nxt_active_mem[head_inc];
			end else begin
				res.head_fault  = cur_fault_mem[head_q];
				res.head_active = cur_active_mem[head_q];
			end
		end
	end

	assign queued_count = fill_next;

	always_comb begin
		ack_req.valid        = pop && (item.wall_ms != '0);
		ack_req.fault        = cur_fault_mem[head_q];
		ack_req.head_wall    = wall_mem[head_q];
		ack_req.head_session = session_mem[head_q];
		ack_req.head_uptime  = uptime_mem[head_q];
		ack_req.report       = item.wall_ms;
		ack_req.session      = item.session_id;
		ack_req.uptime       = item.uptime_ms;
		ack_req.min_time     = min_time;
		ack_req.max_time     = max_time;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("journal fill exceeds its depth");

	a_ptr_align: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 || fill_q == CNT_W'(DEPTH)) |-> (head_q == tail_q))
		else $error("head and tail pointers disagree with the fill count");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (fill_q == $past(fill_q) + 1'b1) && (known_q != '0))
		else $error("append did not grow the journal");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!empty && !push))
		else $error("pop from an empty journal");

endmodule

// ----- src/ftj_ack_time.sv -----
// ---------------------------------------------------------------------------
// ftj_ack_time
// Three-stage pipeline that reconstructs the head's observed time and keeps
// the latest acknowledged time of every fault kind.
// ---------------------------------------------------------------------------
module ftj_ack_time #(
	parameter int FAULT_KINDS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ftj_pkg::ack_req_t ack_req
);

	localparam int TW = ftj_pkg::TIME_W;
	localparam int UW = ftj_pkg::UPTIME_W;

	logic                      v_s2;
	ftj_pkg::ack_req_t req_s2;

	logic                      v_s3, use_pre_s3;
	logic [ftj_pkg::CODE_W-1:0] k_s3;
	logic [TW-1:0]             hwall_s3, report_s3, min_s3, max_s3, rdiff_s3;
	logic [UW-1:0]             elapsed_s3;

	logic                      v_s4;
	logic [ftj_pkg::CODE_W-1:0] k_s4;
	logic [TW-1:0]             obs_s4, report_s4, min_s4, max_s4;

	logic [TW-1:0] ack_time_q [FAULT_KINDS];

	logic [UW:0] up_diff;
	logic [TW:0] rep_diff;
	logic        use_pre;
	logic        use_rec;
	logic [TW-1:0] obs_s3, obs_ok, cur_ack, new_ack;

	// Stage 2: elapsed uptime and slack of the report time above the window floor.
	assign up_diff  = {1'b0, req_s2.uptime} - {1'b0, req_s2.head_uptime};
	assign rep_diff = {1'b0, req_s2.report} - {1'b0, req_s2.min_time};
	assign use_pre  = (req_s2.head_wall == '0) && (req_s2.head_session == req_s2.session)
		&& !up_diff[UW] && !rep_diff[TW];

	// Stage 3: rebuild the event time from the report time when it fits.
	assign use_rec = use_pre_s3 && (elapsed_s3 <= UW'(rdiff_s3));
	assign obs_s3  = use_rec ? report_s3 - elapsed_s3[TW-1:0] : hwall_s3;

	// Stage 4: an observed time outside the window counts as unknown.
	assign obs_ok = ftj_pkg::in_window(obs_s4, min_s4, max_s4) ? obs_s4 : '0;

	always_comb begin
		cur_ack = '0;
		for (int i = 0; i < FAULT_KINDS; i++) begin
			if (32'(k_s4) == i) begin
				cur_ack = ack_time_q[i];
			end
		end
	end

	assign new_ack = (obs_ok == '0 || obs_ok < cur_ack) ? report_s4 : obs_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int i = 0; i < FAULT_KINDS; i++) begin
				ack_time_q[i] <= '0;
			end
		end else begin
			v_s2 <= ack_req.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				for (int i = 0; i < FAULT_KINDS; i++) begin
					if (32'(k_s4) == i) begin
						ack_time_q[i] <= new_ack;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		req_s2 <= ack_req;

		k_s3       <= req_s2.fault;
		hwall_s3   <= req_s2.head_wall;
		report_s3  <= req_s2.report;
		min_s3     <= req_s2.min_time;
		max_s3     <= req_s2.max_time;
		elapsed_s3 <= up_diff[UW-1:0];
		rdiff_s3   <= rep_diff[TW-1:0];
		use_pre_s3 <= use_pre;

		k_s4      <= k_s3;
		obs_s4    <= obs_s3;
		report_s4 <= report_s3;
		min_s4    <= min_s3;
		max_s4    <= max_s3;
	end

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (32'(k_s4) < FAULT_KINDS))
		else $error("acknowledge for a fault kind out of range");

	a_ack_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> (new_ack != '0 || $past(report_s4) == '0) || $past(new_ack) != '0)
		else $error("recorded acknowledge time is zero");

	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |=> v_s3 ##1 v_s4)
		else $error("acknowledge pipeline dropped a request");

endmodule

// ----- src/fault_transition_journal.sv -----
// ---------------------------------------------------------------------------
// fault_transition_journal
// Validates fault transitions, queues them in a ring buffer and pops the
// head on acknowledge, recording the acknowledged time of each fault kind.
// ---------------------------------------------------------------------------
//  channel  | modport | role
//  ---------+---------+----------------------------------------------------
//  item     | sink    | observe / acknowledge request
//  result   | source  | status and queue head after each request
//  cfg      | sink    | window register writes, always ready
//
// One request is taken per cycle while the result is not stalled. A request
// is registered on entry, worked through the journal logic and lands in the
// result register, which drives the result channel. A stalled result holds
// the entry register, which in turn drops item.ready. Reset clears the queue,
// the known fault states and the acknowledged times at once; no sweep runs.
module fault_transition_journal #(
	parameter int JOURNAL_DEPTH = 16,
	parameter int FAULT_KINDS = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	ftj_in_if.sink     item,
	ftj_out_if.source  result,
	ftj_cfg_if.sink    cfg
);

	localparam int CNT_W = $clog2(JOURNAL_DEPTH + 1);

	logic                        in_valid_q;
	ftj_pkg::item_t              item_s1;
	logic                        advance;

	logic                        res_valid_q;
	ftj_pkg::res_t               res_q;
	logic [CNT_W-1:0]            count_q;

	logic [ftj_pkg::TIME_W-1:0]  min_time_q, max_time_q;

	ftj_pkg::res_t               res_d;
	logic [CNT_W-1:0]            count_d;
	ftj_pkg::ack_req_t           ack_req;

	assign advance    = in_valid_q && (!res_valid_q || result.ready);
	assign item.ready = !in_valid_q || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item.valid && item.ready) begin
				in_valid_q <= 1'b1;
			end else if (advance) begin
				in_valid_q <= 1'b0;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.opcode     <= item.opcode;
			item_s1.fault_code <= item.fault_code;
			item_s1.is_active  <= item.is_active;
			item_s1.session_id <= item.session_id;
			item_s1.uptime_ms  <= item.uptime_ms;
			item_s1.wall_ms    <= item.wall_ms;
		end
		if (advance) begin
			res_q   <= res_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_time_q <= ftj_pkg::MIN_TIME_RST;
			max_time_q <= ftj_pkg::MAX_TIME_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				ftj_pkg::REG_MIN_TIME: min_time_q <= cfg.data;
				ftj_pkg::REG_MAX_TIME: max_time_q <= cfg.data;
				default: ;
			endcase
		end
	end

	ftj_journal #(
		.DEPTH(JOURNAL_DEPTH),
		.FAULT_KINDS(FAULT_KINDS)
	) u_journal (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.item(item_s1),
		.min_time(min_time_q),
		.max_time(max_time_q),
		.res(res_d),
		.queued_count(count_d),
		.ack_req(ack_req)
	);

	ftj_ack_time #(
		.FAULT_KINDS(FAULT_KINDS)
	) u_ack_time (
		.clk(clk),
		.arst_n(arst_n),
		.ack_req(ack_req)
	);

	assign result.valid        = res_valid_q;
	assign result.accepted     = res_q.accepted;
	assign result.queued_count = count_q;
	assign result.head_present = res_q.head_present;
	assign result.head_fault   = res_q.head_fault;
	assign result.head_active  = res_q.head_active;

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |=> (res_valid_q && $stable(count_q)))
		else $error("pending result overwritten while stalled");

	a_entry_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid_q |-> item.ready)
		else $error("empty entry register refuses a request");

	a_head_flag: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.head_present == (count_q != '0)))
		else $error("head flag disagrees with queued count");

endmodule
